FILE: design/sxd_pkg.sv
`timescale 1ns / 1ps

package sxd_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned NumKeys = 4;
	localparam int unsigned NumRounds = 32;
	// one stage per half round
	localparam int unsigned NumStages = 2 * NumRounds;

	localparam logic [WordW-1:0] SumInit = 32'hC6EF3720;
	localparam logic [WordW-1:0] DeltaNeg = 32'h61C88647;

	typedef logic [WordW-1:0] word_t;
	typedef logic [NumKeys-1:0][WordW-1:0] key_t;

	typedef struct packed {
		word_t first;
		word_t second;
		key_t  key;
		logic  last;
	} item_t;

	function automatic word_t mix(input word_t v);
		mix = v + ((v << 4) ^ (v >> 5));
	endfunction

endpackage

FILE: design/sxd_front.sv
`timescale 1ns / 1ps

module sxd_front #(
	parameter int unsigned QWORDS_PER_BLOCK = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  sxd_pkg::word_t     cipher_first,
	input  sxd_pkg::word_t     cipher_second,
	input  sxd_pkg::word_t     sector_number,
	input  logic               block_start,
	output sxd_pkg::item_t     item
);

	localparam int unsigned CntW = (QWORDS_PER_BLOCK > 1) ? $clog2(QWORDS_PER_BLOCK) : 1;
	localparam logic [CntW-1:0] LastIdx = CntW'(QWORDS_PER_BLOCK - 1);

	sxd_pkg::key_t   key_q;
	sxd_pkg::key_t   key_cur;
	sxd_pkg::key_t   key_next;
	logic [CntW-1:0] count_q;
	logic [CntW-1:0] count_cur;
	logic            last;

	always_comb begin
		if (block_start) begin
			key_cur   = {sxd_pkg::NumKeys{sector_number}};
			count_cur = '0;
		end else begin
			key_cur   = key_q;
			count_cur = count_q;
		end
		// rolling update, k3 takes the already updated k0
		key_next[0] = key_cur[0] + key_cur[1];
		key_next[1] = key_cur[1] + key_cur[2];
		key_next[2] = key_cur[2] + key_cur[3];
		key_next[3] = key_cur[3] + key_next[0];
		last = (count_cur >= LastIdx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q   <= '0;
			count_q <= '0;
		end else if (push) begin
			key_q   <= key_next;
			count_q <= last ? '0 : count_cur + CntW'(1);
		end
	end

	assign item.first  = cipher_first;
	assign item.second = cipher_second;
	assign item.key    = key_cur;
	assign item.last   = last;

endmodule

FILE: design/sxd_fifo.sv
`timescale 1ns / 1ps

module sxd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sxd_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output sxd_pkg::item_t pop_item
);

	sxd_pkg::item_t mem_q [2];
	logic           wptr_q;
	logic           rptr_q;
	logic [1:0]     count_q;

	assign full     = (count_q == 2'd2);
	assign valid    = (count_q != 2'd0);
	assign pop_item = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: design/sxd_back.sv
`timescale 1ns / 1ps

module sxd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           src_valid,
	input  sxd_pkg::item_t src_item,
	output logic           src_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output sxd_pkg::word_t plain_first,
	output sxd_pkg::word_t plain_second,
	output logic           block_last
);

	localparam int unsigned NStg = sxd_pkg::NumStages;

	logic           vld_s  [NStg];
	sxd_pkg::item_t pipe_s [NStg];
	logic           out_valid_q;
	sxd_pkg::item_t out_q;
	logic           advance;

	// whole pipe moves together whenever the output register frees up
	assign advance = !out_valid_q || out_ready;
	assign src_pop = advance && src_valid;

	for (genvar j = 0; j < NStg; j++) begin : g_stage
		localparam int unsigned Rnd = j / 2;
		localparam logic [31:0] SumY = 32'(sxd_pkg::SumInit + 32'(Rnd) * sxd_pkg::DeltaNeg);
		localparam logic [31:0] SumX = 32'(SumY + sxd_pkg::DeltaNeg);
		localparam logic [1:0]  IdxY = SumY[12:11];
		localparam logic [1:0]  IdxX = SumX[1:0];

		logic           vld_in;
		sxd_pkg::item_t itm_in;
		sxd_pkg::item_t itm_out;

		if (j == 0) begin : g_head
			assign vld_in = src_valid;
			assign itm_in = src_item;
		end else begin : g_link
			assign vld_in = vld_s[j-1];
			assign itm_in = pipe_s[j-1];
		end

		// even stages update the second word, odd stages the first
		if ((j % 2) == 0) begin : g_half_y
			always_comb begin
				itm_out        = itm_in;
				itm_out.second = itm_in.second
					- (sxd_pkg::mix(itm_in.first) ^ (SumY + itm_in.key[IdxY]));
			end
		end else begin : g_half_x
			always_comb begin
				itm_out       = itm_in;
				itm_out.first = itm_in.first
					- (sxd_pkg::mix(itm_in.second) ^ (SumX + itm_in.key[IdxX]));
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (advance) begin
				vld_s[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				pipe_s[j] <= itm_out;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= vld_s[NStg-1];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= pipe_s[NStg-1];
		end
	end

	assign out_valid    = out_valid_q;
	assign plain_first  = out_q.first;
	assign plain_second = out_q.second;
	assign block_last   = out_q.last;

endmodule

FILE: design/sector_xtea_decipher_top.sv
`timescale 1ns / 1ps

// channel  handshake            payload
// in       in_valid / in_ready  cipher_first, cipher_second, sector_number, block_start
// out      out_valid/ out_ready plain_first, plain_second, block_last
//
// one qword per cycle sustained while out_ready stays high; an accepted qword passes through
// one queue slot, 64 half-round stages and one output register
// the front rolls the key and sector count at acceptance; a 2-entry queue feeds the rounds
// arst_n clears the key to zero, the count, the queue and all stage valids
// an output stall freezes the round pipe; the front keeps accepting until the queue fills

module sector_xtea_decipher_top #(
	parameter int unsigned QWORDS_PER_BLOCK = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  sxd_pkg::word_t cipher_first,
	input  sxd_pkg::word_t cipher_second,
	input  sxd_pkg::word_t sector_number,
	input  logic           block_start,
	output logic           out_valid,
	input  logic           out_ready,
	output sxd_pkg::word_t plain_first,
	output sxd_pkg::word_t plain_second,
	output logic           block_last
);

	logic           push;
	logic           q_full;
	logic           q_valid;
	logic           q_pop;
	sxd_pkg::item_t front_item;
	sxd_pkg::item_t q_item;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	sxd_front #(
		.QWORDS_PER_BLOCK(QWORDS_PER_BLOCK)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.cipher_first (cipher_first),
		.cipher_second(cipher_second),
		.sector_number(sector_number),
		.block_start  (block_start),
		.item         (front_item)
	);

	sxd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(front_item),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.pop_item (q_item)
	);

	sxd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.src_valid   (q_valid),
		.src_item    (q_item),
		.src_pop     (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.plain_first (plain_first),
		.plain_second(plain_second),
		.block_last  (block_last)
	);

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int unsigned QWORDS = 64;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned DRAIN_CYCLES = 80;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned RANDOM_ITEMS = 800;
	localparam int unsigned CALM_TAIL = 100;
	localparam int unsigned PRINT_CAP = 30;

	typedef struct packed {
		sxd_pkg::word_t first;
		sxd_pkg::word_t second;
		logic           last;
	} plain_t;

	class plaintext_scoreboard;
		sxd_pkg::word_t roll_key [sxd_pkg::NumKeys];
		int unsigned    qword_idx;
		plain_t         plaintext_q [$];
		int unsigned    errors;
		int unsigned    results_seen;
		int unsigned    lasts_seen;
		int unsigned    sectors_seeded;

		function new();
			foreach (roll_key[i]) roll_key[i] = '0;
			qword_idx = 0;
			errors = 0;
			results_seen = 0;
			lasts_seen = 0;
			sectors_seeded = 0;
		endfunction

		task report(string msg);
			if (errors < PRINT_CAP)
				$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		function automatic sxd_pkg::word_t feistel(sxd_pkg::word_t v);
			return v + ((v << 4) ^ (v >> 5));
		endfunction

		// 32 rounds with sum walking down from 32*delta
		function automatic plain_t decipher_qword(sxd_pkg::word_t c1, sxd_pkg::word_t c2);
			sxd_pkg::word_t sum;
			sxd_pkg::word_t x;
			sxd_pkg::word_t y;
			plain_t         p;
			sum = sxd_pkg::SumInit;
			x = c1;
			y = c2;
			for (int r = 0; r < 32; r++) begin
				y = y - (feistel(x) ^ (sum + roll_key[sum[12:11]]));
				sum = sum + sxd_pkg::DeltaNeg;
				x = x - (feistel(y) ^ (sum + roll_key[sum[1:0]]));
			end
			p.first = x;
			p.second = y;
			p.last = 1'b0;
			return p;
		endfunction

		function void note_input(sxd_pkg::word_t c1, sxd_pkg::word_t c2,
			sxd_pkg::word_t sector, logic start);
			plain_t p;
			if (start) begin
				foreach (roll_key[i]) roll_key[i] = sector;
				qword_idx = 0;
				sectors_seeded++;
			end
			p = decipher_qword(c1, c2);
			// in-order roll, so k3 picks up the fresh k0
			for (int i = 0; i < sxd_pkg::NumKeys; i++)
				roll_key[i] = roll_key[i] + roll_key[(i + 1) % sxd_pkg::NumKeys];
			p.last = (qword_idx >= QWORDS - 1);
			qword_idx = p.last ? 0 : qword_idx + 1;
			plaintext_q.push_back(p);
		endfunction

		task check_result(sxd_pkg::word_t p1, sxd_pkg::word_t p2, logic last);
			plain_t want;
			if (plaintext_q.size() == 0) begin
				report($sformatf("unexpected transaction %h %h last=%b", p1, p2, last));
				return;
			end
			want = plaintext_q.pop_front();
			results_seen++;
			if (last) lasts_seen++;
			if (p1 !== want.first)
				report($sformatf("plain_first got %h want %h", p1, want.first));
			if (p2 !== want.second)
				report($sformatf("plain_second got %h want %h", p2, want.second));
			if (last !== want.last)
				report($sformatf("block_last got %b want %b", last, want.last));
		endtask

		function int unsigned pending();
			return plaintext_q.size();
		endfunction
	endclass

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           in_valid = 1'b0;
	logic           in_ready;
	sxd_pkg::word_t cipher_first = '0;
	sxd_pkg::word_t cipher_second = '0;
	sxd_pkg::word_t sector_number = '0;
	logic           block_start = 1'b0;
	logic           out_valid;
	logic           out_ready = 1'b0;
	sxd_pkg::word_t plain_first;
	sxd_pkg::word_t plain_second;
	logic           block_last;

	plaintext_scoreboard sb = new();
	bit          idle_on = 1'b0;
	bit          hold_req = 1'b0;
	int unsigned items_sent = 0;
	int unsigned cycle_count = 0;

	sector_xtea_decipher_top #(
		.QWORDS_PER_BLOCK(QWORDS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cipher_first (cipher_first),
		.cipher_second(cipher_second),
		.sector_number(sector_number),
		.block_start  (block_start),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.plain_first  (plain_first),
		.plain_second (plain_second),
		.block_last   (block_last)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count, sb.pending());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// both sides are sampled with pre-edge values
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_input(cipher_first, cipher_second, sector_number, block_start);
		if (arst_n && out_valid && out_ready)
			sb.check_result(plain_first, plain_second, block_last);
	end

	// receiver side
	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				hold_req = 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	function automatic sxd_pkg::word_t rand_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_qword(sxd_pkg::word_t c1, sxd_pkg::word_t c2,
		sxd_pkg::word_t sector, logic start);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cipher_first <= c1;
		cipher_second <= c2;
		sector_number <= sector;
		block_start <= start;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_sector(int unsigned len, bit seeded);
		sxd_pkg::word_t sector;
		sector = rand_word();
		for (int unsigned i = 0; i < len; i++) begin
			if (seeded && i == 0)
				send_qword(rand_word(), rand_word(), sector, 1'b1);
			else
				send_qword(rand_word(), rand_word(), $urandom, 1'b0);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	initial begin
		int unsigned kind;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all-zero key straight out of reset, sector number ignored
		send_qword('0, '0, '1, 1'b0);
		send_qword('1, '1, '0, 1'b0);
		send_qword('0, '1, 32'h1234_5678, 1'b0);
		send_qword('1, '0, '1, 1'b0);
		send_qword(32'h8000_0000, 32'h0000_0001, '0, 1'b0);
		// seeded sectors at the extremes, then restarts mid-sector
		send_qword('0, '0, '0, 1'b1);
		send_qword('1, '1, '1, 1'b0);
		send_qword('1, '1, '1, 1'b1);
		send_qword('0, '0, '0, 1'b0);
		send_qword(32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h8000_0000, 1'b1);
		send_qword(32'h5555_5555, 32'hFFFF_FFFE, 32'h0000_0001, 1'b1);
		send_qword(32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
		send_qword($urandom, $urandom, $urandom, 1'b0);
		send_qword($urandom, $urandom, $urandom, 1'b0);
		// sender pauses until the pipe is empty
		wait_drained();

		idle_on = 1'b1;
		// long output stall while the sender keeps going
		hold_req = 1'b1;
		send_sector(QWORDS, 1'b1);
		// run past the end without reseeding, key keeps rolling
		send_sector(QWORDS + 10, 1'b1);
		while (items_sent < RANDOM_ITEMS - CALM_TAIL) begin
			kind = $urandom_range(0, 9);
			if (kind <= 6)
				send_sector(QWORDS, 1'b1);
			else if (kind == 7)
				send_sector($urandom_range(1, QWORDS - 1), 1'b1);
			else if (kind == 8)
				send_sector($urandom_range(1, 10), 1'b0);
			else
				send_sector(QWORDS + $urandom_range(1, 8), 1'b1);
		end

		// back-to-back tail with no idling
		idle_on = 1'b0;
		while (items_sent < RANDOM_ITEMS)
			send_sector(QWORDS, 1'b1);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		while (sb.pending() != 0) begin
			sb.report("result never arrived");
			void'(sb.plaintext_q.pop_front());
		end

		$display("sent %0d qwords in %0d seeded sectors, checked %0d results",
			items_sent, sb.sectors_seeded, sb.results_seen);
		$display("saw %0d end-of-sector marks, %0d mismatches", sb.lasts_seen, sb.errors);
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
